FILE: rtl/gtq_pkg.sv
// Shared types and constants for the grouped team queue.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package gtq_pkg;

  localparam int ELEMENTS = 1024;
  localparam int TEAMS    = 64;
  localparam int EW       = $clog2(ELEMENTS);
  localparam int TW       = $clog2(TEAMS);
  localparam int CW       = $clog2(ELEMENTS + 1);

  typedef logic [EW-1:0] elem_t;
  typedef logic [TW-1:0] team_t;
  typedef logic [CW-1:0] count_t;

  typedef enum logic [1:0] {
    KIND_ASSIGN  = 2'd0,
    KIND_ENQUEUE = 2'd1,
    KIND_DEQUEUE = 2'd2,
    KIND_NONE    = 2'd3
  } kind_t;

  typedef struct packed {
    logic  queued;
    logic  assigned;
    team_t team;
  } member_t;

  typedef struct packed {
    logic load;
    logic clr_step;
    logic asg_wr;
    logic enq_mark;
    logic enq_first;
    logic enq_append;
    logic deq_commit;
    logic deq_head;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic mem_assigned;
    logic mem_queued;
    logic team_busy;
    logic count_zero;
    logic deq_last;
    logic out_free;
  } sts_t;

endpackage

FILE: rtl/gtq_req_if.sv
// Request channel of the grouped team queue: valid/ready plus payload.
// Depends on gtq_pkg.
`timescale 1ns / 1ps

interface gtq_req_if;
  import gtq_pkg::*;

  logic  valid;
  logic  ready;
  kind_t kind;
  elem_t element;
  team_t team;

  modport source (output valid, output kind, output element, output team, input ready);
  modport sink   (input valid, input kind, input element, input team, output ready);
endinterface

FILE: rtl/gtq_res_if.sv
// Result channel of the grouped team queue: valid/ready plus payload.
// Depends on gtq_pkg.
`timescale 1ns / 1ps

interface gtq_res_if;
  import gtq_pkg::*;

  logic  valid;
  logic  ready;
  elem_t element_res;
  team_t team_res;

  modport source (output valid, output element_res, output team_res, input ready);
  modport sink   (input valid, input element_res, input team_res, output ready);
endinterface

FILE: rtl/gtq_ctrl.sv
// Sequencer of the grouped team queue: clearing pass, request decode, command issue.
// Depends on gtq_pkg; drives gtq_dp through cmd_t and reads sts_t.
`timescale 1ns / 1ps

module gtq_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  gtq_pkg::kind_t in_kind,
  output logic          in_ready,
  input  gtq_pkg::sts_t sts,
  output gtq_pkg::cmd_t cmd
);
  import gtq_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ASG,
    S_ENQ,
    S_ENQ_APP,
    S_DEQ,
    S_DEQ_HEAD
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   accept;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          cmd.load = 1'b1;
          unique case (in_kind)
            KIND_ASSIGN:  state_nxt = S_ASG;
            KIND_ENQUEUE: state_nxt = S_ENQ;
            KIND_DEQUEUE: state_nxt = sts.count_zero ? S_IDLE : S_DEQ;
            default:      state_nxt = S_IDLE;
          endcase
        end
      end
      S_ASG: begin
        cmd.asg_wr = !sts.mem_queued;
        state_nxt  = S_IDLE;
      end
      S_ENQ: begin
        state_nxt = S_IDLE;
        if (sts.mem_assigned && !sts.mem_queued) begin
          if (sts.team_busy) begin
            cmd.enq_mark = 1'b1;
            state_nxt    = S_ENQ_APP;
          end else begin
            cmd.enq_first = 1'b1;
          end
        end
      end
      S_ENQ_APP: begin
        cmd.enq_append = 1'b1;
        state_nxt      = S_IDLE;
      end
      S_DEQ: begin
        if (sts.out_free) begin
          cmd.deq_commit = 1'b1;
          state_nxt      = sts.deq_last ? S_IDLE : S_DEQ_HEAD;
        end
      end
      S_DEQ_HEAD: begin
        cmd.deq_head = 1'b1;
        state_nxt    = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.deq_commit |-> sts.out_free)
    else $error("dequeue committed while result register busy");

  a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.clr_step, cmd.asg_wr, cmd.enq_mark, cmd.enq_first,
              cmd.enq_append, cmd.deq_commit, cmd.deq_head}))
    else $error("more than one update command in a cycle");

  a_append_after_mark: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ENQ_APP) |-> $past(cmd.enq_mark))
    else $error("append step reached without tail read");

endmodule

FILE: rtl/gtq_dp.sv
// Datapath of the grouped team queue: membership, link and team memories,
// list pointers, element count and result register. Depends on gtq_pkg.
`timescale 1ns / 1ps

module gtq_dp (
  input  logic          clk,
  input  logic          rst_n,
  input  gtq_pkg::cmd_t cmd,
  output gtq_pkg::sts_t sts,
  input  gtq_pkg::elem_t in_element,
  input  gtq_pkg::team_t in_team,
  output logic          out_valid,
  input  logic          out_ready,
  output gtq_pkg::elem_t out_element_res,
  output gtq_pkg::team_t out_team_res
);
  import gtq_pkg::*;

  member_t member_mem [ELEMENTS];
  elem_t   next_mem   [ELEMENTS];
  elem_t   head_mem   [TEAMS];
  elem_t   tail_mem   [TEAMS];
  team_t   tnext_mem  [TEAMS];

  member_t member_q_r;
  elem_t   next_q_r;
  elem_t   head_q_r;
  elem_t   tail_q_r;
  team_t   tnext_q_r;

  elem_t            elem_r;
  team_t            team_r;
  logic [TEAMS-1:0] tq_r;
  team_t            front_r;
  team_t            back_r;
  count_t           count_r;
  elem_t            clr_r;
  logic             out_valid_r;
  elem_t            out_elem_r;
  team_t            out_team_r;

  team_t   eteam;
  logic    member_we;
  elem_t   member_wa;
  member_t member_wd;
  logic    head_we;
  team_t   head_wa;
  elem_t   head_wd;

  assign eteam = member_q_r.team;

  always_comb begin
    member_we = cmd.clr_step | cmd.asg_wr | cmd.enq_mark | cmd.enq_first | cmd.deq_commit;
    member_wa = elem_r;
    member_wd = '{queued: 1'b1, assigned: 1'b1, team: eteam};
    if (cmd.clr_step) begin
      member_wa = clr_r;
      member_wd = '0;
    end else if (cmd.asg_wr) begin
      member_wd = '{queued: 1'b0, assigned: 1'b1, team: team_r};
    end else if (cmd.deq_commit) begin
      member_wa = head_q_r;
      member_wd = '{queued: 1'b0, assigned: 1'b1, team: front_r};
    end
    head_we = cmd.enq_first | cmd.deq_head;
    head_wa = cmd.deq_head ? front_r : eteam;
    head_wd = cmd.deq_head ? next_q_r : elem_r;
  end

  always_ff @(posedge clk) begin
    if (member_we) member_mem[member_wa] <= member_wd;
    if (cmd.load) member_q_r <= member_mem[in_element];
  end

  always_ff @(posedge clk) begin
    if (cmd.enq_append) next_mem[tail_q_r] <= elem_r;
    if (cmd.deq_commit) next_q_r <= next_mem[head_q_r];
  end

  always_ff @(posedge clk) begin
    if (head_we) head_mem[head_wa] <= head_wd;
    if (cmd.load) head_q_r <= head_mem[front_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.enq_first || cmd.enq_append) tail_mem[eteam] <= elem_r;
    if (cmd.load) begin
      tail_q_r <= tail_mem[front_r];
    end else if (cmd.enq_mark) begin
      tail_q_r <= tail_mem[eteam];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.enq_first && count_r != '0) tnext_mem[back_r] <= eteam;
    if (cmd.load) tnext_q_r <= tnext_mem[front_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      elem_r <= in_element;
      team_r <= in_team;
    end
    if (cmd.deq_commit) begin
      out_elem_r <= head_q_r;
      out_team_r <= front_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tq_r        <= '0;
      front_r     <= '0;
      back_r      <= '0;
      count_r     <= '0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr_step) clr_r <= clr_r + EW'(1);
      if (cmd.enq_first) begin
        tq_r[eteam] <= 1'b1;
        if (count_r == '0) front_r <= eteam;
        back_r <= eteam;
      end
      if (cmd.enq_first || cmd.enq_append) count_r <= count_r + CW'(1);
      if (cmd.deq_commit) begin
        count_r <= count_r - CW'(1);
        if (head_q_r == tail_q_r) begin
          tq_r[front_r] <= 1'b0;
          if (count_r != CW'(1)) front_r <= tnext_q_r;
        end
      end
      if (cmd.deq_commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_comb begin
    sts.clr_last     = (clr_r == EW'(ELEMENTS - 1));
    sts.mem_assigned = member_q_r.assigned;
    sts.mem_queued   = member_q_r.queued;
    sts.team_busy    = tq_r[eteam];
    sts.count_zero   = (count_r == '0);
    sts.deq_last     = (head_q_r == tail_q_r);
    sts.out_free     = !out_valid_r || out_ready;
  end

  assign out_valid       = out_valid_r;
  assign out_element_res = out_elem_r;
  assign out_team_res    = out_team_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(ELEMENTS))
    else $error("element count above capacity");

  a_empty_no_team: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (tq_r == '0))
    else $error("team marked queued while queue empty");

  a_front_queued: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != '0) |-> tq_r[front_r])
    else $error("front team not marked queued");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.deq_commit |=> out_valid_r && (out_elem_r == $past(head_q_r)))
    else $error("result register not loaded by dequeue");

endmodule

FILE: rtl/grouped_team_queue.sv
// Grouped team queue top level: joins the sequencer and the datapath to the channels.
// Depends on gtq_pkg, gtq_req_if, gtq_res_if, gtq_ctrl and gtq_dp.
`timescale 1ns / 1ps

// After reset the block sweeps the 1024-entry membership memory, one entry per cycle,
// and accepts no request until the sweep is done. It then takes one request at a time:
// an assign or enqueue is a read step then a write step (an enqueue of an already
// queued team adds an append step), a dequeue a read step, a commit step once the
// result register is free and a head update step if the team keeps further elements.
// An empty dequeue or unused kind ends at acceptance. Each step does at most one
// registered read or one write per single-port membership, link and team memory. One
// result register sits on the output, so a pending result blocks no new request but a dequeue.

module grouped_team_queue (
  input logic clk,
  input logic rst_n,
  gtq_req_if.sink   in_req,
  gtq_res_if.source out_res
);
  import gtq_pkg::*;

  cmd_t cmd;
  sts_t sts;

  gtq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_kind  (in_req.kind),
    .in_ready (in_req.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  gtq_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_element      (in_req.element),
    .in_team         (in_req.team),
    .out_valid       (out_res.valid),
    .out_ready       (out_res.ready),
    .out_element_res (out_res.element_res),
    .out_team_res    (out_res.team_res)
  );

endmodule
